### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: label");

`endif

### rtl/jsu_pkg.sv
// Package for the JSON string unescaper: decode modes, status codes,
// hex and escape lookups. No dependencies.
package jsu_pkg;

   typedef enum logic [5:0] {
      MODE_PLAIN = 6'b000001,
      MODE_ESC   = 6'b000010,
      MODE_HEX1  = 6'b000100,
      MODE_HEX2  = 6'b001000,
      MODE_HEX3  = 6'b010000,
      MODE_HEX4  = 6'b100000
   } mode_type;

   localparam logic [1:0] ST_BYTE = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

### rtl/json_string_unescape_utf8_top.sv
// JSON string unescaper with UTF-8 output, top level.
// Depends on jsu_pkg and assert_macros.svh.
//
// Usage: feed the string body one byte per request, starting after the
// opening quote; req_end_of_text marks the last byte available. Each
// request gives zero to three responses: decoded bytes (status 0), a done
// result on the closing quote (status 1) or an error (status 2) on a bad
// hex digit or text that ends before the quote. rsp_last_of_run flags the
// final response of a request. After done or error the decoder is back in
// plain mode for the next string.
// A request is held in the input register, then decoded into the response
// register, which presents its first response. Throughput: one request
// per cycle while each gives at most one response and none is stalled; a
// request that gives n responses holds the response register until all
// have drained, one response per cycle while not stalled, so the next
// request waits in the input register meanwhile. The input register takes
// one more request while a response waits. Reset clears all valid state
// and returns the decoder to plain mode. A stalled response holds, and the
// input side stalls once its register is full.
`include "assert_macros.svh"

module json_string_unescape_utf8_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last_of_run
);
   import jsu_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_eot_ff;
   mode_type    mode_ff, mode_in;
   logic [11:0] cp_ff, cp_in;
   logic [1:0]  rem_ff, rem_in;
   logic [7:0]  ob_ff [3];
   logic [7:0]  ob_in [3];
   logic [1:0]  st_ff [3];
   logic [1:0]  st_in [3];

   logic        rsp_fire, req_fire, buf_free, move;
   logic [1:0]  dec_n;
   logic [7:0]  dec_b [3];
   logic [1:0]  dec_s [3];

   assign rsp_valid       = (rem_ff != 2'd0);
   assign rsp_out_byte    = ob_ff[0];
   assign rsp_status      = st_ff[0];
   assign rsp_last_of_run = (rem_ff == 2'd1);
   assign rsp_fire        = rsp_valid && !rsp_stall;
   assign buf_free        = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_fire);
   assign move            = in_vld_ff && buf_free;
   assign req_stall       = in_vld_ff && !move;
   assign req_fire        = req_valid && !req_stall;
   assign in_vld_in       = req_fire || (in_vld_ff && !move);

   always_comb begin
      logic [4:0]  hx;
      logic [15:0] cp;
      hx      = hex_value(in_byte_ff);
      cp      = {cp_ff, hx[3:0]};
      mode_in = mode_ff;
      cp_in   = cp_ff;
      dec_n   = 2'd0;
      for (int i = 0; i < 3; i++) begin
         dec_b[i] = 8'h00;
         dec_s[i] = ST_BYTE;
      end
      unique case (mode_ff)
         MODE_ESC: begin
            if (in_eot_ff) begin
               mode_in  = MODE_PLAIN;
               cp_in    = 12'h000;
               dec_n    = 2'd1;
               dec_s[0] = ST_ERR;
            end else if (in_byte_ff == CH_U) begin
               mode_in = MODE_HEX1;
               cp_in   = 12'h000;
            end else begin
               mode_in  = MODE_PLAIN;
               dec_n    = 2'd1;
               dec_b[0] = escape_byte(in_byte_ff);
            end
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
            if (!hx[4] || in_eot_ff) begin
               mode_in  = MODE_PLAIN;
               cp_in    = 12'h000;
               dec_n    = 2'd1;
               dec_s[0] = ST_ERR;
            end else if (mode_ff != MODE_HEX4) begin
               cp_in = cp[11:0];
               unique case (mode_ff)
                  MODE_HEX1: mode_in = MODE_HEX2;
                  MODE_HEX2: mode_in = MODE_HEX3;
                  default:   mode_in = MODE_HEX4;
               endcase
            end else begin
               mode_in = MODE_PLAIN;
               cp_in   = 12'h000;
               if (cp <= 16'h007F) begin
                  dec_n    = 2'd1;
                  dec_b[0] = cp[7:0];
               end else if (cp <= 16'h07FF) begin
                  dec_n    = 2'd2;
                  dec_b[0] = 8'hC0 | {3'b000, cp[10:6]};
                  dec_b[1] = 8'h80 | {2'b00, cp[5:0]};
               end else begin
                  dec_n    = 2'd3;
                  dec_b[0] = 8'hE0 | {4'h0, cp[15:12]};
                  dec_b[1] = 8'h80 | {2'b00, cp[11:6]};
                  dec_b[2] = 8'h80 | {2'b00, cp[5:0]};
               end
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            cp_in   = 12'h000;
            dec_n   = 2'd1;
            if (in_byte_ff == CH_QUOTE) begin
               dec_s[0] = ST_DONE;
            end else if (in_eot_ff) begin
               dec_s[0] = ST_ERR;
            end else if (in_byte_ff == CH_BSL) begin
               mode_in = MODE_ESC;
               dec_n   = 2'd0;
            end else begin
               dec_b[0] = in_byte_ff;
            end
         end
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      for (int i = 0; i < 3; i++) begin
         ob_in[i] = ob_ff[i];
         st_in[i] = st_ff[i];
      end
      if (move) begin
         rem_in = dec_n;
         for (int i = 0; i < 3; i++) begin
            ob_in[i] = dec_b[i];
            st_in[i] = dec_s[i];
         end
      end else if (rsp_fire) begin
         rem_in   = rem_ff - 2'd1;
         ob_in[0] = ob_ff[1];
         ob_in[1] = ob_ff[2];
         st_in[0] = st_ff[1];
         st_in[1] = st_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         mode_ff   <= MODE_PLAIN;
         cp_ff     <= 12'h000;
         rem_ff    <= 2'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         rem_ff    <= rem_in;
         if (move) begin
            mode_ff <= mode_in;
            cp_ff   <= cp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_eot_ff  <= req_end_of_text;
      end
      for (int i = 0; i < 3; i++) begin
         ob_ff[i] <= ob_in[i];
         st_ff[i] <= st_in[i];
      end
   end

   `ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `ASSERT_NXT(a_drain_cont, clock, reset, rsp_fire && (rem_ff > 2'd1), rsp_valid)
   `ASSERT_NXT(a_in_hold, clock, reset, in_vld_ff && !move,
      in_vld_ff && $stable(in_byte_ff) && $stable(in_eot_ff))
   `ASSERT_IMP(a_end_single, clock, reset, rsp_valid && (rsp_status != ST_BYTE),
      rsp_last_of_run && (rsp_out_byte == 8'h00))

endmodule

### test/testbench.sv
// Self-checking testbench for json_string_unescape_utf8_top: directed and random
// string bodies in, decoded UTF-8 bytes and done/error statuses checked out.
// Depends on jsu_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module testbench;
   import jsu_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last_of_run;
   } rsp_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last_of_run;

   logic       req_fire = 1'b0;
   logic       rsp_fire = 1'b0;

   req_item_type req_backlog[$];
   rsp_item_type rsp_due[$];
   req_item_type next_req;
   rsp_item_type want;
   int         mismatches = 0;
   int         req_gap = 0;
   int         stall_left = 0;
   bit         req_calm = 1'b0;
   bit         rsp_calm = 1'b0;

   mode_type   dec_mode = MODE_PLAIN;
   logic [11:0] dec_acc = '0;

   json_string_unescape_utf8_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last_of_run (rsp_last_of_run)
   );

   function automatic int nibble_of(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 32'h30;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 32'h61 + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 32'h41 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] escaped_result(input logic [7:0] b);
      case (b)
         8'h62:   return 8'h08;
         8'h66:   return 8'h0C;
         8'h6E:   return 8'h0A;
         8'h72:   return 8'h0D;
         8'h74:   return 8'h09;
         default: return b;
      endcase
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + v;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   function automatic rsp_item_type mk_rsp(input logic [7:0] b, input logic [1:0] s);
      rsp_item_type r;
      r.out_byte    = b;
      r.status      = s;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic eot);
      rsp_item_type outs[$];
      int          nib;
      logic [15:0] cp;
      logic        bad;
      bad = 1'b0;
      nib = nibble_of(b);
      case (dec_mode)
         MODE_ESC: begin
            if (eot) begin
               bad = 1'b1;
            end else if (b == CH_U) begin
               dec_mode = MODE_HEX1;
               dec_acc = '0;
            end else begin
               dec_mode = MODE_PLAIN;
               outs.insert(outs.size(), mk_rsp(escaped_result(b), ST_BYTE));
            end
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
            if (nib < 0 || eot) begin
               bad = 1'b1;
            end else begin
               cp = {dec_acc, nib[3:0]};
               if (dec_mode != MODE_HEX4) begin
                  dec_acc = cp[11:0];
                  dec_mode = mode_type'({dec_mode[4:0], 1'b0});
               end else begin
                  dec_mode = MODE_PLAIN;
                  dec_acc = '0;
                  if (cp <= 16'h007F) begin
                     outs.insert(outs.size(), mk_rsp(cp[7:0], ST_BYTE));
                  end else if (cp <= 16'h07FF) begin
                     outs.insert(outs.size(), mk_rsp({3'b110, cp[10:6]}, ST_BYTE));
                     outs.insert(outs.size(), mk_rsp({2'b10, cp[5:0]}, ST_BYTE));
                  end else begin
                     outs.insert(outs.size(), mk_rsp({4'hE, cp[15:12]}, ST_BYTE));
                     outs.insert(outs.size(), mk_rsp({2'b10, cp[11:6]}, ST_BYTE));
                     outs.insert(outs.size(), mk_rsp({2'b10, cp[5:0]}, ST_BYTE));
                  end
               end
            end
         end
         default: begin
            dec_mode = MODE_PLAIN;
            dec_acc = '0;
            if (b == CH_QUOTE) begin
               outs.insert(outs.size(), mk_rsp(8'h00, ST_DONE));
            end else if (eot) begin
               bad = 1'b1;
            end else if (b == CH_BSL) begin
               dec_mode = MODE_ESC;
            end else begin
               outs.insert(outs.size(), mk_rsp(b, ST_BYTE));
            end
         end
      endcase
      if (bad) begin
         outs = {};
         outs.insert(outs.size(), mk_rsp(8'h00, ST_ERR));
         dec_mode = MODE_PLAIN;
         dec_acc = '0;
      end
      if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
      foreach (outs[i]) rsp_due.insert(rsp_due.size(), outs[i]);
   endtask

   task automatic add_req(input logic [7:0] b, input logic eot);
      req_item_type r;
      r.data_byte   = b;
      r.end_of_text = eot;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic add_random_string();
      int          tokens;
      int          pick;
      int          digits;
      logic [7:0]  b;
      logic [15:0] cp;
      logic        ended;
      tokens = $urandom_range(1, 12);
      ended = 1'b0;
      for (int t = 0; t < tokens && !ended; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
            ended = ($urandom_range(0, 49) == 0);
            add_req(b, ended);
         end else if (pick < 60) begin
            add_req(CH_BSL, 1'b0);
            case ($urandom_range(0, 8))
               0:       b = CH_QUOTE;
               1:       b = CH_BSL;
               2:       b = 8'h2F;
               3:       b = 8'h62;
               4:       b = 8'h66;
               5:       b = 8'h6E;
               6:       b = 8'h72;
               7:       b = 8'h74;
               default: do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            endcase
            ended = ($urandom_range(0, 49) == 0);
            add_req(b, ended);
         end else if (pick < 85) begin
            add_req(CH_BSL, 1'b0);
            add_req(CH_U, 1'b0);
            case ($urandom_range(0, 2))
               0:       cp = 16'($urandom_range(0, 16'h007F));
               1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
               default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            for (int k = 0; k < 4; k++) add_req(hex_char(cp[15 - 4 * k -: 4]), 1'b0);
         end else if (pick < 90) begin
            add_req(CH_BSL, 1'b0);
            add_req(CH_U, 1'b0);
            digits = $urandom_range(0, 3);
            for (int k = 0; k < digits; k++) add_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
            if ($urandom_range(0, 1)) begin
               do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
               add_req(b, 1'b0);
            end else begin
               add_req(hex_char(4'($urandom_range(0, 15))), 1'b1);
            end
            ended = 1'b1;
         end else if (pick < 95) begin
            add_req(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            add_req(CH_QUOTE, 1'($urandom_range(0, 1)));
            ended = 1'b1;
         end
      end
      if (!ended) add_req(CH_QUOTE, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // directed: byte extremes, escapes, two- and three-byte UTF-8 sequences, done and error paths
   initial begin
      add_req(8'h00, 1'b0);
      add_req(8'hFF, 1'b0);
      add_req(CH_BSL, 1'b0);
      add_req(CH_QUOTE, 1'b0);
      add_req(CH_BSL, 1'b0);
      add_req("n", 1'b0);
      add_req(CH_BSL, 1'b0);
      add_req(CH_U, 1'b0);
      add_req("0", 1'b0);
      add_req("7", 1'b0);
      add_req("f", 1'b0);
      add_req("F", 1'b0);
      add_req(CH_BSL, 1'b0);
      add_req(CH_U, 1'b0);
      repeat (4) add_req("F", 1'b0);
      add_req(CH_QUOTE, 1'b1);
      add_req(CH_BSL, 1'b0);
      add_req(CH_U, 1'b0);
      add_req("1", 1'b0);
      add_req("g", 1'b0);
      add_req("a", 1'b1);
      add_req(CH_BSL, 1'b1);
      while (req_backlog.size() < 425) add_random_string();

      wait (!reset);
      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // hold
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (req_backlog.size() > 0) begin
            next_req = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_req.data_byte;
            req_end_of_text <= next_req.end_of_text;
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            req_gap = req_calm ? 0 : $urandom_range(0, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, 15);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         dec_mode = MODE_PLAIN;
         dec_acc = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected response out_byte=%h status=%0d last=%b",
                        $time, rsp_out_byte, rsp_status, rsp_last_of_run);
               mismatches++;
            end else begin
               want = rsp_due.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_status !== want.status ||
                   rsp_last_of_run !== want.last_of_run) begin
                  $display("%0t: expected out_byte=%h status=%0d last=%b, got %h %0d %b",
                           $time, want.out_byte, want.status, want.last_of_run,
                           rsp_out_byte, rsp_status, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_end_of_text);
      end
   end

endmodule

### files.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8_top.sv
test/testbench.sv
